// ===== rtl/i2a_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

	// longest text: twenty unsigned decimal digits
	localparam int MaxChars     = 20;
	localparam int DigW         = MaxChars * 4;
	localparam int CntW         = 5;
	localparam int DefValueBits = 64;

	localparam logic [6:0] AsciiMinus = 7'h2D;
	localparam logic [6:0] AsciiZero  = 7'h30;
	// 'A' minus ten
	localparam logic [6:0] AsciiHexBase = 7'h37;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic conv_step;
		logic skip_step;
		logic emit_sign;
		logic emit_digit;
	} i2a_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_hex;
		logic negative;
		logic conv_last;
		logic top_zero;
		logic cnt_one;
		logic out_free;
	} i2a_sts_t;

	// ascii code of one digit, 0-9 then A-F
	function automatic logic [6:0] hex_char(input logic [3:0] d);
		logic [6:0] r;
		if (d < 4'd10) begin
			r = AsciiZero + {3'b000, d};
		end else begin
			r = AsciiHexBase + {3'b000, d};
		end
		return r;
	endfunction

	// bits needed to hold the value n
	function automatic int num_bits(input int n);
		int r;
		r = 1;
		for (int i = 0; i < 31; i++) begin
			if ((1 << i) <= n) begin
				r = i + 1;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/i2a_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_dpath
// Operand load, bit-serial binary to BCD conversion, leading zero skip and
// the registered character output.
// ----------------------------------------------------------------------------
module i2a_dpath #(
	parameter int VALUE_BITS = i2a_pkg::DefValueBits
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire i2a_pkg::i2a_cmd_t cmd,
	output i2a_pkg::i2a_sts_t     sts,
	input  wire logic [1:0]       op,
	input  wire logic [63:0]      value,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [6:0]            char_code,
	output logic                  last
);
	import i2a_pkg::*;

	localparam int BitCntW = num_bits(VALUE_BITS);

	logic [VALUE_BITS-1:0] v_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] bin_q;
	logic [DigW-1:0]       dig_q;
	logic [DigW-1:0]       dig_adj;
	logic [BitCntW-1:0]    bitcnt_q;
	logic [CntW-1:0]       cnt_q;
	logic                  neg_q;
	logic                  out_valid_q;
	logic [6:0]            char_q;
	logic                  last_q;
	logic [3:0]            top_dig;

	// operand masking and magnitude of a negative signed value
	assign v_in   = value[VALUE_BITS-1:0];
	assign neg_in = (op == 2'b00) && v_in[VALUE_BITS-1];
	assign mag_in = neg_in ? ((~v_in) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v_in;

	// add-three correction on every BCD digit before the shift
	always_comb begin
		for (int i = 0; i < MaxChars; i++) begin
			if (dig_q[i*4 +: 4] >= 4'd5) begin
				dig_adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
			end else begin
				dig_adj[i*4 +: 4] = dig_q[i*4 +: 4];
			end
		end
	end

	assign top_dig = dig_q[DigW-1 -: 4];

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			bitcnt_q    <= '0;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				bitcnt_q <= BitCntW'(VALUE_BITS);
				cnt_q    <= CntW'(MaxChars);
				neg_q    <= neg_in;
			end else if (cmd.conv_step) begin
				bitcnt_q <= bitcnt_q - BitCntW'(1);
			end else if (cmd.skip_step || cmd.emit_digit) begin
				cnt_q <= cnt_q - CntW'(1);
			end
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// digit and operand shift registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag_in;
			if (op[1]) begin
				dig_q <= {{(DigW-VALUE_BITS){1'b0}}, v_in};
			end else begin
				dig_q <= '0;
			end
		end else if (cmd.conv_step) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			dig_q <= {dig_adj[DigW-2:0], bin_q[VALUE_BITS-1]};
		end else if (cmd.skip_step || cmd.emit_digit) begin
			dig_q <= {dig_q[DigW-5:0], 4'h0};
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= AsciiMinus;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= hex_char(top_dig);
			last_q <= (cnt_q == CntW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	// status to the controller
	always_comb begin
		sts.is_hex    = op[1];
		sts.negative  = neg_q;
		sts.conv_last = (bitcnt_q == BitCntW'(1));
		sts.top_zero  = (top_dig == 4'h0);
		sts.cnt_one   = (cnt_q == CntW'(1));
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule
`default_nettype wire

// ===== rtl/i2a_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_ctrl
// Sequencer: accept, convert, skip leading zeros, sign, then emit digits.
// ----------------------------------------------------------------------------
module i2a_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire i2a_pkg::i2a_sts_t sts,
	output i2a_pkg::i2a_cmd_t      cmd
);
	import i2a_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.is_hex ? ST_SKIP : ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_last) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (sts.top_zero && !sts.cnt_one) begin
					cmd.skip_step = 1'b1;
				end else begin
					state_d = sts.negative ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.cnt_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// at most one datapath command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.conv_step, cmd.skip_step, cmd.emit_sign, cmd.emit_digit}))
		else $error("i2a_ctrl: more than one datapath command");

	// a character is only written into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
		else $error("i2a_ctrl: character written over a pending word");

	// skipping never drops a nonzero digit or the final digit
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.skip_step |-> (sts.top_zero && !sts.cnt_one))
		else $error("i2a_ctrl: skipped a significant digit");

	// the final digit returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_digit && sts.cnt_one) |=> (state_q == ST_IDLE))
		else $error("i2a_ctrl: no return to idle after final digit");

endmodule
`default_nettype wire

// ===== rtl/integer_to_ascii_converter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_converter
// Converts one integer to signed decimal, unsigned decimal or uppercase
// hexadecimal ASCII text, one character per output word, last one marked.
// ----------------------------------------------------------------------------
// One number is worked on at a time. After the input word is taken, a decimal
// conversion runs one shift-and-add-three step per operand bit; hexadecimal
// skips this. Leading zero digits of the twenty-digit register are then
// dropped at one per cycle (up to 19). A minus sign for a negative number and
// then each character leave when the output side is ready. The last character
// sits in the output register while the next number is already accepted.
module integer_to_ascii_converter #(
	parameter int VALUE_BITS = i2a_pkg::DefValueBits
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [63:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       char_code,
	output logic             last
);
	import i2a_pkg::*;

	i2a_cmd_t cmd;
	i2a_sts_t sts;

	// sequencer
	i2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// conversion datapath and output register
	i2a_dpath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last      (last)
	);

endmodule
`default_nettype wire
